### rtl/md5de_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine package
// Shared types and constants: round constants, shift amounts, initial value.
// ----------------------------------------------------------------------------
package md5de_pkg;

   localparam logic [31:0] IV_A = 32'h67452301;
   localparam logic [31:0] IV_B = 32'hefcdab89;
   localparam logic [31:0] IV_C = 32'h98badcfe;
   localparam logic [31:0] IV_D = 32'h10325476;

   localparam int QUEUE_DEPTH = 4;

   // one queued byte item
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } byte_item_type;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
   } digest_type;

   function automatic logic [31:0] sine_const(input logic [5:0] i);
      logic [31:0] k;
      begin
         case (i)
            6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
         endcase
         return k;
      end
   endfunction

   // per-round left rotate amount
   function automatic logic [4:0] rot_amount(input logic [5:0] i);
      logic [4:0] r;
      begin
         case ({i[5:4], i[1:0]})
            4'b0000: r = 5'd7;  4'b0001: r = 5'd12; 4'b0010: r = 5'd17; 4'b0011: r = 5'd22;
            4'b0100: r = 5'd5;  4'b0101: r = 5'd9;  4'b0110: r = 5'd14; 4'b0111: r = 5'd20;
            4'b1000: r = 5'd4;  4'b1001: r = 5'd11; 4'b1010: r = 5'd16; 4'b1011: r = 5'd23;
            4'b1100: r = 5'd6;  4'b1101: r = 5'd10; 4'b1110: r = 5'd15; default: r = 5'd21;
         endcase
         return r;
      end
   endfunction

   // message word index used by each round
   function automatic logic [3:0] word_index(input logic [5:0] i);
      logic [3:0] g;
      begin
         case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(({2'b0, i} * 8'd5) + 8'd1);
            2'd2: g = 4'(({2'b0, i} * 8'd3) + 8'd5);
            default: g = 4'({2'b0, i} * 8'd7);
         endcase
         return g;
      end
   endfunction

endpackage

### rtl/md5de_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 byte queue
// Short queue of byte items between the stream front end and the core.
// ----------------------------------------------------------------------------
module md5de_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   output logic                    push_ready,
   input  md5de_pkg::byte_item_type push_item,
   output logic                    pop_valid,
   input  logic                    pop_ready,
   output md5de_pkg::byte_item_type pop_item
);
   localparam int AW = $clog2(md5de_pkg::QUEUE_DEPTH);

   md5de_pkg::byte_item_type mem_ff [md5de_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]   count_ff, count_in;
   logic          push, pop;

   assign push_ready = (count_ff != (AW+1)'(md5de_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_item   = mem_ff[rptr_ff];
   assign push = push_valid & push_ready;
   assign pop  = pop_valid & pop_ready;

   // pointer and fill count update
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_item;
      end
   end
endmodule

### rtl/md5de_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 compression core
// Packs bytes into the block, pads at the final byte, runs one round a
// cycle, and holds the digest in an output register.
// ----------------------------------------------------------------------------
module md5de_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  md5de_pkg::byte_item_type in_item,
   output logic                     out_valid,
   input  logic                     out_ready,
   output md5de_pkg::digest_type    out_digest
);
   typedef enum logic [4:0] {
      ST_LOAD  = 5'b00001,
      ST_PAD   = 5'b00010,
      ST_ROUND = 5'b00100,
      ST_FOLD  = 5'b01000,
      ST_EMIT  = 5'b10000
   } state_type;

   state_type    state_ff, state_in;
   logic [31:0]  block_ff [16];
   logic [5:0]   pos_ff, pos_in;
   logic [63:0]  bitlen_ff, bitlen_in;
   logic [5:0]   round_ff, round_in;
   logic [31:0]  a_ff, b_ff, c_ff, d_ff, a_in, b_in, c_in, d_in;
   md5de_pkg::digest_type chain_ff, chain_in;
   logic         final_ff, final_in;   // padding in progress
   logic         len_ff, len_in;       // this block carries the length
   logic         pad_first_ff, pad_first_in;   // 0x80 still owed to the padding
   logic         out_valid_ff, out_valid_in;
   md5de_pkg::digest_type dig_ff;

   logic         byte_we;
   logic [7:0]   byte_val;
   logic         take;
   logic [31:0]  f, sum, rot;
   logic [5:0]   ri;
   logic [4:0]   sh;

   assign take      = in_valid & in_ready;
   assign in_ready  = (state_ff == ST_LOAD);
   assign out_valid = out_valid_ff;
   assign out_digest = dig_ff;
   assign ri = round_ff;
   assign sh = md5de_pkg::rot_amount(ri);

   // round function
   always_comb begin
      case (ri[5:4])
         2'd0: f = (b_ff & c_ff) | (~b_ff & d_ff);
         2'd1: f = (d_ff & b_ff) | (~d_ff & c_ff);
         2'd2: f = b_ff ^ c_ff ^ d_ff;
         default: f = c_ff ^ (b_ff | ~d_ff);
      endcase
      sum = a_ff + f + md5de_pkg::sine_const(ri) + block_ff[md5de_pkg::word_index(ri)];
      rot = (sum << sh) | (sum >> (6'd32 - {1'b0, sh}));
   end

   // control sequencing
   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      bitlen_in = bitlen_ff;
      round_in = round_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff;
      chain_in = chain_ff;
      final_in = final_ff;
      len_in = len_ff;
      out_valid_in = out_valid_ff & ~out_ready;
      byte_we = 1'b0;
      byte_val = 8'h00;
      case (state_ff)
         ST_LOAD: begin
            if (take) begin
               byte_we = 1'b1;
               byte_val = in_item.data_byte;
               pos_in = pos_ff + 6'd1;
               bitlen_in = bitlen_ff + 64'd8;
               final_in = in_item.final_byte;
               if (in_item.final_byte) begin
                  state_in = ST_PAD;
                  if (pos_ff == 6'd63) begin
                     // block fills exactly; 0x80 goes into the next block
                     state_in = ST_ROUND;
                     a_in = chain_ff.a; b_in = chain_ff.b;
                     c_in = chain_ff.c; d_in = chain_ff.d;
                  end
               end else if (pos_ff == 6'd63) begin
                  state_in = ST_ROUND;
                  a_in = chain_ff.a; b_in = chain_ff.b;
                  c_in = chain_ff.c; d_in = chain_ff.d;
               end
            end
         end
         ST_PAD: begin
            // first pad byte is 0x80 while it is still owed, zeros after it
            byte_we = 1'b1;
            byte_val = (final_ff && !len_ff && pad_first_ff) ? 8'h80 : 8'h00;
            pos_in = pos_ff + 6'd1;
            if (pos_ff == 6'd55) begin
               len_in = 1'b1;
               pos_in = 6'd0;
               state_in = ST_ROUND;
               a_in = chain_ff.a; b_in = chain_ff.b;
               c_in = chain_ff.c; d_in = chain_ff.d;
            end else if (pos_ff == 6'd63) begin
               state_in = ST_ROUND;
               a_in = chain_ff.a; b_in = chain_ff.b;
               c_in = chain_ff.c; d_in = chain_ff.d;
            end
         end
         ST_ROUND: begin
            a_in = d_ff; d_in = c_ff; c_in = b_ff;
            b_in = b_ff + rot;
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            chain_in.a = chain_ff.a + a_ff; chain_in.b = chain_ff.b + b_ff;
            chain_in.c = chain_ff.c + c_ff; chain_in.d = chain_ff.d + d_ff;
            if (len_ff) begin
               state_in = ST_EMIT;
            end else if (final_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_EMIT: begin
            if (!out_valid_ff || out_ready) begin
               out_valid_in = 1'b1;
               chain_in = '{md5de_pkg::IV_A, md5de_pkg::IV_B,
                            md5de_pkg::IV_C, md5de_pkg::IV_D};
               bitlen_in = '0;
               final_in = 1'b0;
               len_in = 1'b0;
               pos_in = '0;
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // 0x80 still owed to the padding
   always_comb begin
      pad_first_in = pad_first_ff;
      if (take && in_item.final_byte) begin
         pad_first_in = 1'b1;
      end else if (state_ff == ST_PAD) begin
         pad_first_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         pos_ff       <= '0;
         bitlen_ff    <= '0;
         round_ff     <= '0;
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
         chain_ff     <= '{md5de_pkg::IV_A, md5de_pkg::IV_B,
                           md5de_pkg::IV_C, md5de_pkg::IV_D};
         final_ff     <= 1'b0;
         len_ff       <= 1'b0;
         pad_first_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         bitlen_ff    <= bitlen_in;
         round_ff     <= round_in;
         a_ff <= a_in; b_ff <= b_in; c_ff <= c_in; d_ff <= d_in;
         chain_ff     <= chain_in;
         final_ff     <= final_in;
         len_ff       <= len_in;
         pad_first_ff <= pad_first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // block word store; the length words land when padding reaches them
   always_ff @(posedge clock) begin
      if (byte_we) begin
         case (pos_ff[1:0])
            2'd0: block_ff[pos_ff[5:2]] <= {24'h0, byte_val};
            2'd1: block_ff[pos_ff[5:2]][15:8] <= byte_val;
            2'd2: block_ff[pos_ff[5:2]][23:16] <= byte_val;
            default: block_ff[pos_ff[5:2]][31:24] <= byte_val;
         endcase
      end
      if (state_ff == ST_PAD && pos_ff == 6'd55) begin
         block_ff[14] <= bitlen_ff[31:0];
         block_ff[15] <= bitlen_ff[63:32];
      end
   end

   // digest output register
   always_ff @(posedge clock) begin
      if (state_ff == ST_EMIT && (!out_valid_ff || out_ready)) begin
         dig_ff <= chain_ff;
      end
   end
endmodule

### rtl/md5_digest_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine top level
// Byte stream in, 128-bit digest out, one result per message.
// ----------------------------------------------------------------------------
// Bytes enter through a four-item queue and are packed into the block at one
// byte per cycle while the core is loading; every full 64-byte block then runs
// 64 rounds at one round per cycle and a fold step, during which the core takes
// no bytes. After the byte with tlast, padding writes one byte a cycle up to the
// length field and needs one or two more compressions before the digest
// appears on rsp. The digest register frees the core for the next message
// while a result waits.
module md5_digest_engine_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // data_byte
   input  logic         req_tlast,   // final_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata    // digest_a, digest_b, digest_c, digest_d
);
   md5de_pkg::byte_item_type q_in, q_out;
   md5de_pkg::digest_type    dig;
   logic q_valid, q_ready;

   assign q_in = '{data_byte: req_tdata, final_byte: req_tlast};

   md5de_queue u_queue (
      .clock(clock), .reset(reset),
      .push_valid(req_tvalid), .push_ready(req_tready), .push_item(q_in),
      .pop_valid(q_valid), .pop_ready(q_ready), .pop_item(q_out)
   );

   md5de_core u_core (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_out),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_digest(dig)
   );

   assign rsp_tdata = {dig.d, dig.c, dig.b, dig.a};
endmodule
